### design/wssf_pkg.sv
package wssf_pkg;

  // Field widths
  localparam int ADDR_W  = 4;
  localparam int SPEED_W = 16;
  localparam int CNT_W   = 5;
  localparam int THR_W   = 15;
  localparam int MBC_W   = 4;
  localparam int CFG_W   = 15;
  localparam int CFG_IDX_W = 1;

  // Defaults
  localparam int NUM_ENTRIES_DEF = 16;
  localparam logic [THR_W-1:0] JUMP_THRESHOLD_RESET = 15'd100;
  localparam logic [MBC_W-1:0] MAX_BAD_COUNT_RESET  = 4'd3;
  localparam logic [CNT_W-1:0] COUNT_TOP            = 5'd31;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_JUMP_THRESHOLD = 1'd0,
    REG_MAX_BAD_COUNT  = 1'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [ADDR_W-1:0]         encoder_addr;
    logic signed [SPEED_W-1:0] driven_speed_in;
    logic signed [SPEED_W-1:0] idler_speed_in;
    logic signed [SPEED_W-1:0] speed_diff_in;
    logic signed [SPEED_W-1:0] slip_ratio_in;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0]         encoder_addr_out;
    logic signed [SPEED_W-1:0] driven_speed_out;
    logic signed [SPEED_W-1:0] idler_speed_out;
    logic                      driven_rejected;
    logic                      idler_rejected;
    logic signed [SPEED_W-1:0] speed_diff_out;
    logic signed [SPEED_W-1:0] slip_ratio_out;
  } out_item_t;

  typedef struct packed {
    logic [THR_W-1:0] jump_threshold;
    logic [MBC_W-1:0] max_bad_count;
  } cfg_t;

  // One stored entry of a lane
  typedef struct packed {
    logic signed [SPEED_W-1:0] speed;
    logic [CNT_W-1:0]          cnt;
  } entry_t;

  // What one lane found for the item in its compare stage
  typedef struct packed {
    logic signed [SPEED_W-1:0] speed;
    logic                      rejected;
  } lane_res_t;

endpackage

### design/wssf_lane.sv
module wssf_lane #(
  parameter int NUM_ENTRIES = wssf_pkg::NUM_ENTRIES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  wssf_pkg::cfg_t                      cfg_i,
  input  logic                                rd_en_i,
  input  logic [$clog2(NUM_ENTRIES)-1:0]      rd_idx_i,
  input  logic                                wr_en_i,
  input  logic [$clog2(NUM_ENTRIES)-1:0]      wr_idx_i,
  input  logic signed [wssf_pkg::SPEED_W-1:0] reading_i,
  output wssf_pkg::lane_res_t                 res_o
);
  import wssf_pkg::*;

  localparam int EXT_W = SPEED_W + 2;

  entry_t                 mem_q [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] vld_q;
  entry_t                 rd_q;
  logic                   rd_vld_q;
  logic                   byp_q;
  entry_t                 byp_data_q;

  entry_t                 cur;
  entry_t                 wr_entry;
  logic signed [EXT_W-1:0] st_x, rd_x, thr_x, hi_x, lo_x;
  logic                   in_win;
  logic                   take;

  // Entry memory: read on item accept, written back from the compare stage
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i] <= wr_entry;
    end
    if (rd_en_i) begin
      rd_q       <= mem_q[rd_idx_i];
      byp_data_q <= wr_entry;
    end
  end

  // Valid bits and same-edge write bypass flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      byp_q    <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_idx_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_idx_i];
        byp_q    <= wr_en_i && (wr_idx_i == rd_idx_i);
      end
    end
  end

  // Current entry: bypassed write, stored value, or zero if never written
  always_comb begin
    if (byp_q) begin
      cur = byp_data_q;
    end else if (rd_vld_q) begin
      cur = rd_q;
    end else begin
      cur = '0;
    end
  end

  // Open window compare and persistence decision
  always_comb begin
    st_x   = {{2{cur.speed[SPEED_W-1]}}, cur.speed};
    rd_x   = {{2{reading_i[SPEED_W-1]}}, reading_i};
    thr_x  = {{(EXT_W-THR_W){1'b0}}, cfg_i.jump_threshold};
    hi_x   = st_x + thr_x;
    lo_x   = st_x - thr_x;
    in_win = (rd_x < hi_x) && (rd_x > lo_x);
    take   = in_win || (cur.cnt > {1'b0, cfg_i.max_bad_count});

    if (take) begin
      wr_entry.speed = reading_i;
      wr_entry.cnt   = '0;
    end else begin
      wr_entry.speed = cur.speed;
      wr_entry.cnt   = (cur.cnt < COUNT_TOP) ? cur.cnt + CNT_W'(1) : cur.cnt;
    end

    res_o.speed    = wr_entry.speed;
    res_o.rejected = !take;
  end

endmodule

### design/wssf_out_reg.sv
module wssf_out_reg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                load_i,
  input  logic                                in_range_i,
  input  wssf_pkg::in_item_t                  item_i,
  input  wssf_pkg::lane_res_t                 driven_i,
  input  wssf_pkg::lane_res_t                 idler_i,
  input  logic                                out_stall_i,
  output logic                                ready_o,
  output logic                                out_valid_o,
  output wssf_pkg::out_item_t                 out_data_o
);
  import wssf_pkg::*;

  logic      vld_q;
  out_item_t data_q, data_d;

  assign ready_o     = !vld_q || !out_stall_i;
  assign out_valid_o = vld_q;
  assign out_data_o  = data_q;

  // Merge the two lanes with the pass-through fields
  always_comb begin
    data_d.encoder_addr_out = item_i.encoder_addr;
    data_d.speed_diff_out   = item_i.speed_diff_in;
    data_d.slip_ratio_out   = item_i.slip_ratio_in;
    if (in_range_i) begin
      data_d.driven_speed_out = driven_i.speed;
      data_d.idler_speed_out  = idler_i.speed;
      data_d.driven_rejected  = driven_i.rejected;
      data_d.idler_rejected   = idler_i.rejected;
    end else begin
      data_d.driven_speed_out = '0;
      data_d.idler_speed_out  = '0;
      data_d.driven_rejected  = 1'b1;
      data_d.idler_rejected   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && ready_o) begin
      data_q <= data_d;
    end
  end

endmodule

### design/wheel_speed_spike_filter_top.sv
// Channel  Direction  Handshake               Payload
// in       input      in_valid_i / in_stall_o in_data_i  (in_item_t)
// out      output     out_valid_o/ out_stall_i out_data_o (out_item_t)
// cfg      input      cfg_we_i                cfg_idx_i, cfg_data_i
//
// One item per cycle sustained while out_stall_i is low; an accepted item is
// registered in stage 1, then its result in the output register.
// Stage 1 reads the driven and idler entry memories, stage 2 compares in both
// lanes, writes back and loads the output register; a same-address write in
// the accept cycle is bypassed. Reset clears valid bits, so every entry reads
// as zero until written; no clearing pass. A stalled output holds stage 2 and
// stalls the input only when both stages are full.
module wheel_speed_spike_filter_top #(
  parameter int NUM_ENTRIES = wssf_pkg::NUM_ENTRIES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [wssf_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [wssf_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  wssf_pkg::in_item_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output wssf_pkg::out_item_t               out_data_o
);
  import wssf_pkg::*;

  localparam int IDX_W = $clog2(NUM_ENTRIES);
  localparam int MW    = (IDX_W > ADDR_W) ? IDX_W : ADDR_W;

  cfg_t      cfg_q;
  logic      s1_vld_q;
  in_item_t  s1_q;
  logic      ready;
  logic      advance;
  logic      accept;
  logic      s1_range;
  logic [MW-1:0]    in_addr_x, s1_addr_x;
  logic [IDX_W-1:0] rd_idx, wr_idx;
  lane_res_t driven_res, idler_res;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.jump_threshold <= JUMP_THRESHOLD_RESET;
      cfg_q.max_bad_count  <= MAX_BAD_COUNT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_JUMP_THRESHOLD: cfg_q.jump_threshold <= cfg_data_i[THR_W-1:0];
        REG_MAX_BAD_COUNT:  cfg_q.max_bad_count  <= cfg_data_i[MBC_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake and stage control
  assign advance    = s1_vld_q && ready;
  assign in_stall_o = s1_vld_q && !ready;
  assign accept     = in_valid_i && !in_stall_o;

  // Address to entry index
  assign in_addr_x = MW'(in_data_i.encoder_addr);
  assign s1_addr_x = MW'(s1_q.encoder_addr);
  assign rd_idx    = in_addr_x[IDX_W-1:0];
  assign wr_idx    = s1_addr_x[IDX_W-1:0];
  assign s1_range  = 32'(s1_q.encoder_addr) < 32'(NUM_ENTRIES);

  // Stage 1 item register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (accept) begin
      s1_vld_q <= 1'b1;
    end else if (advance) begin
      s1_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= in_data_i;
    end
  end

  // Driven and idler lanes
  wssf_lane #(
    .NUM_ENTRIES(NUM_ENTRIES)
  ) u_driven (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .rd_en_i  (accept),
    .rd_idx_i (rd_idx),
    .wr_en_i  (advance && s1_range),
    .wr_idx_i (wr_idx),
    .reading_i(s1_q.driven_speed_in),
    .res_o    (driven_res)
  );

  wssf_lane #(
    .NUM_ENTRIES(NUM_ENTRIES)
  ) u_idler (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .rd_en_i  (accept),
    .rd_idx_i (rd_idx),
    .wr_en_i  (advance && s1_range),
    .wr_idx_i (wr_idx),
    .reading_i(s1_q.idler_speed_in),
    .res_o    (idler_res)
  );

  // Merge and output register
  wssf_out_reg u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (s1_vld_q),
    .in_range_i (s1_range),
    .item_i     (s1_q),
    .driven_i   (driven_res),
    .idler_i    (idler_res),
    .out_stall_i(out_stall_i),
    .ready_o    (ready),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o)
  );

endmodule

### tb/wheel_speed_spike_filter_top_test.sv
`timescale 1ns / 100ps

module wheel_speed_spike_filter_top_test;
  import wssf_pkg::*;

  localparam int ENTRIES     = NUM_ENTRIES_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEMS_PER_PHASE = 75;

  // Next value of one lane entry after filtering a reading
  typedef struct packed {
    logic signed [SPEED_W-1:0] speed;
    logic [CNT_W-1:0]          cnt;
    logic                      rejected;
  } lane_state_t;

  logic             clk_i      = 1'b0;
  logic             rst_ni     = 1'b0;
  logic             cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  in_item_t         in_data_i  = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  out_item_t        out_data_o;

  wheel_speed_spike_filter_top #(
    .NUM_ENTRIES(ENTRIES)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // Filter state as the block should hold it
  logic [THR_W-1:0]          thr_model = JUMP_THRESHOLD_RESET;
  logic [MBC_W-1:0]          mbc_model = MAX_BAD_COUNT_RESET;
  logic signed [SPEED_W-1:0] driven_store [ENTRIES];
  logic signed [SPEED_W-1:0] idler_store  [ENTRIES];
  logic [CNT_W-1:0]          driven_cnt   [ENTRIES];
  logic [CNT_W-1:0]          idler_cnt    [ENTRIES];

  in_item_t  pending_readings [$];
  out_item_t expected_outputs [$];

  int error_count  = 0;
  int results_seen = 0;
  int cycle_count  = 0;

  // Window test plus persistence count for one speed lane
  function automatic lane_state_t filter_lane(logic signed [SPEED_W-1:0] reading,
                                              logic signed [SPEED_W-1:0] stored,
                                              logic [CNT_W-1:0] cnt);
    lane_state_t nxt;
    int r;
    int s;
    int t;
    bit in_window;
    r = reading;
    s = stored;
    t = thr_model;
    in_window = (r < s + t) && (r > s - t);
    if (in_window || cnt > {1'b0, mbc_model}) begin
      nxt.speed    = reading;
      nxt.cnt      = '0;
      nxt.rejected = 1'b0;
    end else begin
      nxt.speed    = stored;
      nxt.cnt      = (cnt < COUNT_TOP) ? cnt + 1'b1 : cnt;
      nxt.rejected = 1'b1;
    end
    return nxt;
  endfunction

  // Expected output for one accepted reading; updates the state copy
  function automatic out_item_t predict_filter_step(in_item_t it);
    out_item_t   res;
    lane_state_t d;
    lane_state_t i;
    int          a;
    a = it.encoder_addr;
    res.encoder_addr_out = it.encoder_addr;
    res.speed_diff_out   = it.speed_diff_in;
    res.slip_ratio_out   = it.slip_ratio_in;
    if (a < ENTRIES) begin
      d = filter_lane(it.driven_speed_in, driven_store[a], driven_cnt[a]);
      i = filter_lane(it.idler_speed_in, idler_store[a], idler_cnt[a]);
      driven_store[a] = d.speed;
      driven_cnt[a]   = d.cnt;
      idler_store[a]  = i.speed;
      idler_cnt[a]    = i.cnt;
      res.driven_speed_out = d.speed;
      res.idler_speed_out  = i.speed;
      res.driven_rejected  = d.rejected;
      res.idler_rejected   = i.rejected;
    end else begin
      // no entry behind this address: nothing stored, both held back
      res.driven_speed_out = '0;
      res.idler_speed_out  = '0;
      res.driven_rejected  = 1'b1;
      res.idler_rejected   = 1'b1;
    end
    return res;
  endfunction

  function automatic logic signed [SPEED_W-1:0] clamp_speed(int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[SPEED_W-1:0];
  endfunction

  task automatic add_reading(int addr, int drv, int idl, int diff, int slip);
    in_item_t it;
    it.encoder_addr    = addr[ADDR_W-1:0];
    it.driven_speed_in = drv[SPEED_W-1:0];
    it.idler_speed_in  = idl[SPEED_W-1:0];
    it.speed_diff_in   = diff[SPEED_W-1:0];
    it.slip_ratio_in   = slip[SPEED_W-1:0];
    pending_readings.push_back(it);
  endtask

  // Block until every queued reading went in and its output came back
  task automatic wait_drained();
    while (pending_readings.size() != 0 || in_valid_i || expected_outputs.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      REG_JUMP_THRESHOLD: thr_model = value[THR_W-1:0];
      REG_MAX_BAD_COUNT:  mbc_model = value[MBC_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_filter(logic [CFG_W-1:0] thr, logic [CFG_W-1:0] mbc);
    write_reg(REG_JUMP_THRESHOLD, thr);
    write_reg(REG_MAX_BAD_COUNT, mbc);
  endtask

  // Random readings: mostly plausible drift around a per-address speed,
  // some spike runs long enough to get past the persistence count, some noise
  task automatic add_random_phase(int count);
    int nom_d [ENTRIES];
    int nom_i [ENTRIES];
    int added;
    int kind;
    int addr;
    int span;
    int run_len;
    int spike_d;
    int spike_i;
    int k;
    int dv;
    int iv;
    added = 0;
    for (k = 0; k < ENTRIES; k++) begin
      nom_d[k] = driven_store[k];
      nom_i[k] = idler_store[k];
    end
    while (added < count) begin
      kind = $urandom_range(0, 99);
      addr = $urandom_range(0, ENTRIES - 1);
      span = thr_model;
      if (kind < 65) begin
        dv = nom_d[addr] + $urandom_range(0, 2 * span + 2) - (span + 1);
        iv = nom_i[addr] + $urandom_range(0, 2 * span + 2) - (span + 1);
        dv = clamp_speed(dv);
        iv = clamp_speed(iv);
        nom_d[addr] = dv;
        nom_i[addr] = iv;
        add_reading(addr, dv, iv, $urandom, $urandom);
        added++;
      end else if (kind < 80) begin
        run_len = $urandom_range(1, mbc_model + 3);
        spike_d = clamp_speed(nom_d[addr] + $urandom_range(0, 65535) - 32768);
        spike_i = clamp_speed(nom_i[addr] + $urandom_range(0, 65535) - 32768);
        for (k = 0; k < run_len; k++) begin
          dv = clamp_speed(spike_d + $urandom_range(0, 8) - 4);
          iv = ($urandom_range(0, 3) == 0) ? nom_i[addr] :
               clamp_speed(spike_i + $urandom_range(0, 8) - 4);
          add_reading(addr, dv, iv, $urandom, $urandom);
          added++;
        end
        if (run_len > mbc_model) begin
          nom_d[addr] = spike_d;
          nom_i[addr] = spike_i;
        end
      end else begin
        add_reading(addr, $urandom, $urandom, $urandom, $urandom);
        added++;
      end
    end
  endtask

  // Sender: bursts of random length with random gaps
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      if (in_valid_i && !in_stall_o)
        expected_outputs.push_back(predict_filter_step(in_data_i));
      if (in_valid_i && in_stall_o) begin
        // stalled: hold the item
      end else if (gap_left > 0) begin
        in_valid_i <= 1'b0;
        gap_left--;
      end else if (pending_readings.size() > 0) begin
        if (burst_left == 0) burst_left = $urandom_range(1, 24);
        in_valid_i <= 1'b1;
        in_data_i  <= pending_readings.pop_front();
        burst_left--;
        if (burst_left == 0)
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: checks outputs, stalls on a rotating pattern plus long hold-offs
  int pattern_cycle = 0;
  int hold_left     = 0;
  int holds_done    = 0;
  int next_hold_at  = 30;

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (expected_outputs.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("unexpected output item: addr=%0d drv=%0d idl=%0d",
                     out_data_o.encoder_addr_out, out_data_o.driven_speed_out,
                     out_data_o.idler_speed_out);
        end else begin
          want = expected_outputs.pop_front();
          if (out_data_o.encoder_addr_out !== want.encoder_addr_out ||
              out_data_o.driven_speed_out !== want.driven_speed_out ||
              out_data_o.idler_speed_out  !== want.idler_speed_out  ||
              out_data_o.driven_rejected  !== want.driven_rejected  ||
              out_data_o.idler_rejected   !== want.idler_rejected   ||
              out_data_o.speed_diff_out   !== want.speed_diff_out   ||
              out_data_o.slip_ratio_out   !== want.slip_ratio_out) begin
            error_count++;
            if (error_count <= 10) begin
              $display(
                "mismatch %0d: expected addr=%0d drv=%0d idl=%0d rej=%b%b diff=%0d slip=%0d",
                results_seen, want.encoder_addr_out, want.driven_speed_out,
                want.idler_speed_out, want.driven_rejected, want.idler_rejected,
                want.speed_diff_out, want.slip_ratio_out);
              $display("  actual addr=%0d drv=%0d idl=%0d rej=%b%b diff=%0d slip=%0d",
                       out_data_o.encoder_addr_out, out_data_o.driven_speed_out,
                       out_data_o.idler_speed_out, out_data_o.driven_rejected,
                       out_data_o.idler_rejected, out_data_o.speed_diff_out,
                       out_data_o.slip_ratio_out);
            end
          end
        end
      end

      pattern_cycle++;
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (holds_done < 2 && results_seen >= next_hold_at &&
                   pending_readings.size() > 30) begin
        // long hold-off so the pipeline backs up into the input
        hold_left = 60;
        holds_done++;
        next_hold_at = results_seen + 150;
        out_stall_i <= 1'b1;
      end else begin
        case ((pattern_cycle / 50) % 4)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          2: out_stall_i <= ($urandom_range(0, 3) != 0);
          default: out_stall_i <= (pattern_cycle % 3 == 0);
        endcase
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("wheel_speed_spike_filter_top_test: errors");
      $finish;
    end
  end

  initial begin
    int k;
    for (k = 0; k < ENTRIES; k++) begin
      driven_store[k] = '0;
      idler_store[k]  = '0;
      driven_cnt[k]   = '0;
      idler_cnt[k]    = '0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset settings: window edges and a spike that persists past the count
    add_reading(0, 0, 0, 32767, -32768);
    add_reading(0, 99, -99, -32768, 32767);
    add_reading(0, 199, -199, 0, -1);
    for (k = 0; k < 5; k++)
      add_reading(1, 32767, -32768, -1 - k, k);
    add_reading(15, -32768, 32767, 16'h5555, 16'haaaa);
    wait_drained();

    // Zero threshold, zero max bad count: every reading is outside
    set_filter(15'd0, 15'd0);
    add_reading(2, 0, 0, 1, 2);
    add_reading(2, 0, 0, 3, 4);
    add_reading(2, 0, 0, 5, 6);
    add_reading(2, 7, -7, 7, 8);
    wait_drained();

    // Widest window, most tolerated rejects
    set_filter(15'h7fff, 15'd15);
    add_reading(1, -32768, 32767, 16'haaaa, 16'h5555);
    add_reading(1, 1, -1, 0, 0);
    add_reading(3, -32768, 32767, 32767, 32767);
    add_reading(3, 32767, -32768, -32768, -32768);
    add_reading(3, -1, 1, 0, 0);
    wait_drained();

    // Random phases over a spread of settings
    set_filter(CFG_W'($urandom_range(1, 400)), CFG_W'($urandom_range(0, 15)));
    add_random_phase(ITEMS_PER_PHASE);
    wait_drained();
    set_filter(15'd0, CFG_W'($urandom_range(0, 15)));
    add_random_phase(ITEMS_PER_PHASE);
    wait_drained();
    set_filter(15'h7fff, 15'd15);
    add_random_phase(ITEMS_PER_PHASE);
    wait_drained();
    set_filter(CFG_W'($urandom_range(0, 32767)), 15'd0);
    add_random_phase(ITEMS_PER_PHASE);
    wait_drained();
    set_filter(CFG_W'($urandom_range(0, 32767)), CFG_W'($urandom_range(0, 15)));
    add_random_phase(ITEMS_PER_PHASE);
    wait_drained();
    set_filter(15'd50, 15'd15);
    add_random_phase(ITEMS_PER_PHASE);
    wait_drained();
    repeat (8) @(posedge clk_i);

    if (error_count == 0 && expected_outputs.size() == 0)
      $display("wheel_speed_spike_filter_top_test: clean");
    else
      $display("wheel_speed_spike_filter_top_test: errors");
    $finish;
  end

endmodule
